[sv/windowed_average_with_majority_macros.svh]
// Assertion macros for the windowed average block.
// Used by the top level; depends on nothing.
`ifndef WINDOWED_AVERAGE_WITH_MAJORITY_MACROS_SVH
`define WINDOWED_AVERAGE_WITH_MAJORITY_MACROS_SVH
// Condition implies consequence in the same cycle.
`define WAM_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Condition implies consequence in the next cycle.
`define WAM_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[sv/wam_pkg.sv]
// Shared constants and types for the windowed average block.
// No dependencies.
package wam_pkg;
  localparam int unsigned TW        = 32;
  localparam int unsigned VW        = 20;
  localparam int unsigned LW        = 20;
  localparam int unsigned STW       = 3;
  localparam int unsigned ENW       = 5;
  localparam int unsigned NCH       = 6;
  localparam int unsigned NST       = 5;
  localparam int unsigned MAX_COUNT = 1024;
  localparam int unsigned CW        = $clog2(MAX_COUNT + 1);
  localparam int unsigned SW        = VW + $clog2(MAX_COUNT);
  localparam int unsigned DW        = SW + 1;
  localparam int unsigned DCW       = $clog2(DW);
  localparam int unsigned CHW       = $clog2(NCH);

  typedef enum logic [1:0] {
    REG_RANGE_START = 2'd0,
    REG_RANGE_END   = 2'd1,
    REG_WINDOW_LEN  = 2'd2,
    REG_STATUS_EN   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] dividend;
    logic [CW-1:0] divisor;
  } div_req_t;
endpackage

[sv/wam_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on wam_pkg.
module wam_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wam_pkg::div_req_t      req_i,
  output logic [wam_pkg::DW-1:0] quotient_o,
  output logic                   done_o
);
  logic                    busy_q, done_q;
  logic [wam_pkg::DCW-1:0] cnt_q;
  logic [wam_pkg::CW-1:0]  rem_q, dvs_q;
  logic [wam_pkg::DW-1:0]  quo_q;
  logic [wam_pkg::CW:0]    rem_sh;
  logic                    qbit;

  always_comb begin
    rem_sh = {rem_q, quo_q[wam_pkg::DW-1]};
    qbit   = rem_sh >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= wam_pkg::DCW'(wam_pkg::DW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? wam_pkg::CW'(rem_sh - {1'b0, dvs_q}) : rem_sh[wam_pkg::CW-1:0];
      quo_q <= {quo_q[wam_pkg::DW-2:0], qbit};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;
endmodule

[sv/windowed_average_with_majority.sv]
// A record that only accumulates passes through transfer, check and one add per channel.
// A closing record runs the shared bit-serial divider once per channel mean, with one setup
// step before and one sign-fix step after each division, then waits to emit its result.
// No new record is taken until the last one is through; the result sits in an
// output register so the next record transfers while it waits. Reset (async, low) clears
// control state and loads register defaults; window contents are rebuilt when a window opens.
module windowed_average_with_majority (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [wam_pkg::TW-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wam_pkg::TW-1:0]        record_time_i,
  input  logic signed [wam_pkg::VW-1:0] outdoor_temp_i,
  input  logic signed [wam_pkg::VW-1:0] indoor_temp_i,
  input  logic signed [wam_pkg::VW-1:0] mirror_temp_i,
  input  logic signed [wam_pkg::VW-1:0] wind_i,
  input  logic signed [wam_pkg::VW-1:0] air_pressure_i,
  input  logic signed [wam_pkg::VW-1:0] humidity_level_i,
  input  logic [wam_pkg::STW-1:0]       status_code_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wam_pkg::TW-1:0]        mid_time_o,
  output logic signed [wam_pkg::VW-1:0] avg_outdoor_o,
  output logic signed [wam_pkg::VW-1:0] avg_indoor_o,
  output logic signed [wam_pkg::VW-1:0] avg_mirror_o,
  output logic signed [wam_pkg::VW-1:0] avg_wind_o,
  output logic signed [wam_pkg::VW-1:0] avg_pressure_o,
  output logic signed [wam_pkg::VW-1:0] avg_humidity_o,
  output logic [wam_pkg::STW-1:0]       major_status_o
);
  `include "windowed_average_with_majority_macros.svh"

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EVAL = 7'b0000010,
    S_ACC  = 7'b0000100,
    S_PREP = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FIX  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [wam_pkg::TW-1:0]  range_start_q, range_end_q;
  logic [wam_pkg::LW-1:0]  window_len_q;
  logic [wam_pkg::ENW-1:0] status_en_q;

  // Control state.
  logic                    started_q, finished_q, out_valid_q;
  logic [wam_pkg::CHW-1:0] ch_q;

  // Held record.
  logic [wam_pkg::TW-1:0]  time_q;
  logic [wam_pkg::VW-1:0]  val_q [wam_pkg::NCH];
  logic [wam_pkg::STW-1:0] st_q;

  // Window contents.
  logic [wam_pkg::TW-1:0]  first_q, last_q, mid_q;
  logic [wam_pkg::SW-1:0]  sum_q [wam_pkg::NCH];
  logic [wam_pkg::CW-1:0]  count_q;
  logic [wam_pkg::CW-1:0]  tally_q [wam_pkg::NST];
  logic [wam_pkg::VW-1:0]  quot_q [wam_pkg::NCH];
  logic [wam_pkg::STW-1:0] major_q;

  // Output register.
  logic [wam_pkg::TW-1:0]  mid_out_q;
  logic [wam_pkg::VW-1:0]  avg_out_q [wam_pkg::NCH];
  logic [wam_pkg::STW-1:0] major_out_q;

  logic [wam_pkg::VW-1:0]  val_in [wam_pkg::NCH];
  logic                    in_fire, t_lt_start, t_gt_end, st_ok, close_win;
  logic                    eval_open, emit_fire, last_ch;
  logic [wam_pkg::LW-1:0]  len;
  logic [wam_pkg::TW-1:0]  t_diff;
  logic [wam_pkg::SW-1:0]  sum_sel, sum_mag;
  logic                    sum_neg;
  logic [wam_pkg::DW-1:0]  quo;
  logic                    div_done;
  wam_pkg::div_req_t       div_req;
  logic [wam_pkg::CW-1:0]  best;
  logic [wam_pkg::STW-1:0] best_code;

  assign val_in[0] = outdoor_temp_i;
  assign val_in[1] = indoor_temp_i;
  assign val_in[2] = mirror_temp_i;
  assign val_in[3] = wind_i;
  assign val_in[4] = air_pressure_i;
  assign val_in[5] = humidity_level_i;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    len        = (window_len_q == '0) ? wam_pkg::LW'(1) : window_len_q;
    t_diff     = time_q - first_q;
    t_lt_start = time_q < range_start_q;
    t_gt_end   = time_q > range_end_q;
    // Drop codes past the last status before looking at the enable mask.
    st_ok      = (st_q < wam_pkg::STW'(wam_pkg::NST)) && status_en_q[st_q];
    close_win  = ((time_q >= first_q) &&
                  (t_diff >= {{(wam_pkg::TW - wam_pkg::LW){1'b0}}, len})) ||
                 (count_q >= wam_pkg::CW'(wam_pkg::MAX_COUNT));
    eval_open  = (state_q == S_EVAL) && !finished_q && !t_lt_start && !t_gt_end &&
                 st_ok && !started_q;
    emit_fire  = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
    last_ch    = (ch_q == wam_pkg::CHW'(wam_pkg::NCH - 1));
    sum_sel    = sum_q[ch_q];
    sum_neg    = sum_sel[wam_pkg::SW-1];
    sum_mag    = sum_neg ? wam_pkg::SW'(-sum_sel) : sum_sel;
    // Bias by half the count so the quotient rounds half away from zero.
    div_req.start    = (state_q == S_PREP);
    div_req.divisor  = count_q;
    div_req.dividend = {1'b0, sum_mag} +
                       {{(wam_pkg::DW - wam_pkg::CW + 1){1'b0}}, count_q[wam_pkg::CW-1:1]};
    // Most frequent status; the first code wins a tie.
    best      = '0;
    best_code = '0;
    for (int s = 0; s < wam_pkg::NST; s++) begin
      if (tally_q[s] > best) begin
        best      = tally_q[s];
        best_code = wam_pkg::STW'(s);
      end
    end
  end

  wam_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_EVAL;
      S_EVAL: begin
        if (finished_q || t_lt_start || t_gt_end || !st_ok || !started_q) begin
          state_d = S_IDLE;
        end else if (close_win) begin
          state_d = S_PREP;
        end else begin
          state_d = S_ACC;
        end
      end
      S_ACC:  if (last_ch) state_d = S_IDLE;
      S_PREP: state_d = S_DIV;
      S_DIV:  if (div_done) state_d = S_FIX;
      S_FIX:  state_d = last_ch ? S_EMIT : S_PREP;
      S_EMIT: if (emit_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      ch_q          <= '0;
      started_q     <= 1'b0;
      finished_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      range_start_q <= '0;
      range_end_q   <= '1;
      window_len_q  <= wam_pkg::LW'(1);
      status_en_q   <= '1;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (wam_pkg::cfg_reg_e'(cfg_idx_i))
          wam_pkg::REG_RANGE_START: range_start_q <= cfg_data_i;
          wam_pkg::REG_RANGE_END:   range_end_q   <= cfg_data_i;
          wam_pkg::REG_WINDOW_LEN:  window_len_q  <= cfg_data_i[wam_pkg::LW-1:0];
          wam_pkg::REG_STATUS_EN:   status_en_q   <= cfg_data_i[wam_pkg::ENW-1:0];
          default: ;
        endcase
      end
      if (state_q == S_EVAL) begin
        ch_q <= '0;
        // A late record stops everything from here on.
        if (!finished_q && !t_lt_start && t_gt_end) finished_q <= 1'b1;
      end
      if (eval_open) started_q <= 1'b1;
      if (state_q == S_ACC || state_q == S_FIX) ch_q <= last_ch ? '0 : ch_q + 1'b1;
      // Load a new result, or drop the old one once it transfers.
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      time_q <= record_time_i;
      st_q   <= status_code_i;
      for (int c = 0; c < wam_pkg::NCH; c++) val_q[c] <= val_in[c];
    end
    if (state_q == S_ACC) begin
      sum_q[ch_q] <= sum_sel + wam_pkg::SW'(signed'(val_q[ch_q]));
      if (last_ch) begin
        last_q         <= time_q;
        count_q        <= count_q + 1'b1;
        tally_q[st_q]  <= tally_q[st_q] + 1'b1;
      end
    end
    if (state_q == S_PREP && ch_q == '0) begin
      mid_q   <= {1'b0, first_q[wam_pkg::TW-1:1]} + {1'b0, last_q[wam_pkg::TW-1:1]};
      major_q <= best_code;
    end
    if (state_q == S_FIX) begin
      quot_q[ch_q] <= sum_neg ? wam_pkg::VW'(-quo) : quo[wam_pkg::VW-1:0];
    end
    if (emit_fire) begin
      mid_out_q   <= mid_q;
      major_out_q <= major_q;
      for (int c = 0; c < wam_pkg::NCH; c++) avg_out_q[c] <= quot_q[c];
    end
    // Restart the window with the held record.
    if (eval_open || emit_fire) begin
      first_q <= time_q;
      last_q  <= time_q;
      count_q <= wam_pkg::CW'(1);
      for (int c = 0; c < wam_pkg::NCH; c++) begin
        sum_q[c] <= wam_pkg::SW'(signed'(val_q[c]));
      end
      for (int s = 0; s < wam_pkg::NST; s++) begin
        tally_q[s] <= (wam_pkg::STW'(s) == st_q) ? wam_pkg::CW'(1) : '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mid_time_o     = mid_out_q;
  assign avg_outdoor_o  = avg_out_q[0];
  assign avg_indoor_o   = avg_out_q[1];
  assign avg_mirror_o   = avg_out_q[2];
  assign avg_wind_o     = avg_out_q[3];
  assign avg_pressure_o = avg_out_q[4];
  assign avg_humidity_o = avg_out_q[5];
  assign major_status_o = major_out_q;

  `WAM_ASSERT_NXT(a_finish_sticks, clk_i, rst_ni, finished_q, finished_q)
  `WAM_ASSERT_IMP(a_done_in_div, clk_i, rst_ni, div_done, state_q == S_DIV)
  `WAM_ASSERT_IMP(a_rise_from_emit, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == S_EMIT)
  `WAM_ASSERT_IMP(a_count_bound, clk_i, rst_ni, started_q && state_q == S_IDLE,
                  count_q <= wam_pkg::CW'(wam_pkg::MAX_COUNT))
endmodule
